### rtl/core/csl_pkg.sv
// Shared types, token codes and byte classification for the lexer.
// Used by csl_ctrl, csl_dp and c_subset_lexer_unit; no dependencies.
package csl_pkg;

  localparam int OUT_LIMIT = 10;
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  localparam logic [4:0] KIND_END     = 5'd0;
  localparam logic [4:0] KIND_PLUS    = 5'd1;
  localparam logic [4:0] KIND_MINUS   = 5'd2;
  localparam logic [4:0] KIND_STAR    = 5'd3;
  localparam logic [4:0] KIND_SLASH   = 5'd4;
  localparam logic [4:0] KIND_LPAREN  = 5'd5;
  localparam logic [4:0] KIND_RPAREN  = 5'd6;
  localparam logic [4:0] KIND_LBRACE  = 5'd7;
  localparam logic [4:0] KIND_RBRACE  = 5'd8;
  localparam logic [4:0] KIND_SEMI    = 5'd9;
  localparam logic [4:0] KIND_ASSIGN  = 5'd10;
  localparam logic [4:0] KIND_EQ      = 5'd11;
  localparam logic [4:0] KIND_NE      = 5'd12;
  localparam logic [4:0] KIND_GT      = 5'd13;
  localparam logic [4:0] KIND_GE      = 5'd14;
  localparam logic [4:0] KIND_LT      = 5'd15;
  localparam logic [4:0] KIND_LE      = 5'd16;
  localparam logic [4:0] KIND_NUMBER  = 5'd17;
  localparam logic [4:0] KIND_IDENT   = 5'd18;
  localparam logic [4:0] KIND_INT     = 5'd19;
  localparam logic [4:0] KIND_VOID    = 5'd20;
  localparam logic [4:0] KIND_RETURN  = 5'd21;
  localparam logic [4:0] KIND_PRINT   = 5'd22;
  localparam logic [4:0] KIND_UNKNOWN = 5'd23;
  localparam logic [4:0] KIND_BANG    = 5'd24;
  localparam logic [4:0] KIND_TOOLONG = 5'd25;
  localparam logic [4:0] KIND_TEXT    = 5'd26;

  // keywords packed first character in the low byte
  localparam logic [23:0] KW_INT    = 24'h746E69;
  localparam logic [31:0] KW_VOID   = 32'h64696F76;
  localparam logic [47:0] KW_RETURN = 48'h6E7275746572;
  localparam logic [39:0] KW_PRINT  = 40'h746E697270;

  typedef enum logic [1:0] {
    MODE_IDLE, MODE_NUMBER, MODE_IDENT, MODE_DISCARD
  } mode_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_ASSIGN, OP_BANG, OP_LESS, OP_GREATER
  } op_t;

  typedef enum logic [2:0] {
    FC_SKIP, FC_SINGLE, FC_PEND, FC_DIGIT, FC_LETTER, FC_UNKNOWN
  } fclass_t;

  typedef enum logic [1:0] {
    SEL_TOKEN, SEL_IDHEAD, SEL_WORD, SEL_FRESH
  } sel_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_TOKEN, S_IDHEAD, S_WORD, S_FRESH
  } state_t;

  typedef struct packed {
    logic  capture;
    logic  eval;
    logic  pend_clear;
    logic  acc_step;
    logic  id_push;
    logic  mode_we;
    mode_t mode_val;
    logic  fresh;
    logic  word_clr;
    logic  word_inc;
    logic  emit;
    sel_t  sel;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic  pend_any;
    logic  eq;
    mode_t mode;
    logic  digit;
    logic  alnum;
    logic  id_full;
    logic  is_kw;
    logic  fresh_emits;
    logic  word_last;
    logic  slot_free;
  } status_t;

  function automatic fclass_t classify(input logic [7:0] c);
    fclass_t r;
    case (c) inside
      8'h20, 8'h09, 8'h0A, 8'h0B: r = FC_SKIP;
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3B: r = FC_SINGLE;
      8'h3D, 8'h21, 8'h3C, 8'h3E: r = FC_PEND;
      [8'h30:8'h39]: r = FC_DIGIT;
      [8'h61:8'h7A], [8'h41:8'h5A]: r = FC_LETTER;
      default: r = FC_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h2B: k = KIND_PLUS;
      8'h2D: k = KIND_MINUS;
      8'h2A: k = KIND_STAR;
      8'h2F: k = KIND_SLASH;
      8'h28: k = KIND_LPAREN;
      8'h29: k = KIND_RPAREN;
      8'h7B: k = KIND_LBRACE;
      8'h7D: k = KIND_RBRACE;
      default: k = KIND_SEMI;
    endcase
    return k;
  endfunction

  function automatic op_t pend_op(input logic [7:0] c);
    op_t o;
    case (c)
      8'h3D: o = OP_ASSIGN;
      8'h21: o = OP_BANG;
      8'h3C: o = OP_LESS;
      default: o = OP_GREATER;
    endcase
    return o;
  endfunction

  function automatic logic [4:0] op_kind(input op_t op, input logic eq);
    logic [4:0] k;
    case (op)
      OP_ASSIGN: k = eq ? KIND_EQ : KIND_ASSIGN;
      OP_BANG:   k = eq ? KIND_NE : KIND_BANG;
      OP_LESS:   k = eq ? KIND_LE : KIND_LT;
      default:   k = eq ? KIND_GE : KIND_GT;
    endcase
    return k;
  endfunction

endpackage

### rtl/core/c_subset_lexer_unit.sv
// Top level of the C subset lexer: controller plus datapath.
// Depends on csl_pkg, csl_ctrl, csl_dp (and csl_ram through csl_dp).
//
//   channel  handshake            payload
//   input    in_valid/in_stall    byte_req, end_of_input
//   output   out_valid/out_stall  kind, value, id_length, text, line, last
//
// Capture and evaluate come first; a digit or letter that extends a
// number or identifier needs no more. Each token adds an emit state, and a
// byte lexed afresh (idle, or after the token it ends) adds a fresh state
// with its own token if any; a non-keyword identifier is sent as a head plus 8-byte words.
// Emission holds while the output register keeps a stalled transaction.
// Reset: line counter to 1, lexer idle, no pending operator.
module c_subset_lexer_unit #(
  parameter int MAX_ID = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    byte_req,
  input  logic                          end_of_input,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [4:0]                    kind,
  output logic [31:0]                   value,
  output logic [$clog2(MAX_ID+1)-1:0]   id_length,
  output logic [63:0]                   text,
  output logic [23:0]                   line,
  output logic                          last
);
  import csl_pkg::*;

  cmd_t    cmd;
  status_t st;

  csl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  csl_dp #(.MAX_ID(MAX_ID)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .byte_req     (byte_req),
    .end_of_input (end_of_input),
    .cmd          (cmd),
    .st           (st),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .kind         (kind),
    .value        (value),
    .id_length    (id_length),
    .text         (text),
    .line         (line),
    .last         (last)
  );
endmodule

### rtl/core/csl_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
module csl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/csl_ctrl.sv
// Lexer controller: sequences capture, evaluation and token emission.
// Depends on csl_pkg; drives csl_dp through cmd_t, reads status_t.
module csl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  csl_pkg::status_t st,
  output csl_pkg::cmd_t    cmd
);
  import csl_pkg::*;

  state_t     state, state_next;
  logic       fresh_need, fresh_need_next;
  logic [3:0] emit_cnt;
  logic       can_emit, go;

  assign can_emit = emit_cnt < 4'(OUT_LIMIT);
  // past the result limit, walk on without output
  assign go       = st.slot_free || !can_emit;
  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fresh_need <= 1'b0;
      emit_cnt   <= '0;
    end else begin
      state      <= state_next;
      fresh_need <= fresh_need_next;
      if (cmd.capture) begin
        emit_cnt <= '0;
      end else if (cmd.emit) begin
        emit_cnt <= emit_cnt + 4'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (st.pend_any) begin
          state_next = S_TOKEN;
        end else begin
          case (st.mode)
            MODE_NUMBER:  state_next = st.digit ? S_IDLE : S_TOKEN;
            MODE_IDENT: begin
              if (st.alnum) state_next = st.id_full ? S_TOKEN : S_IDLE;
              else          state_next = st.is_kw ? S_TOKEN : S_IDHEAD;
            end
            MODE_DISCARD: state_next = st.alnum ? S_IDLE : S_FRESH;
            default:      state_next = S_FRESH;
          endcase
        end
      end
      S_TOKEN: begin
        if (go) state_next = fresh_need ? S_FRESH : S_IDLE;
      end
      S_IDHEAD: begin
        if (go) state_next = S_WORD;
      end
      S_WORD: begin
        if (go && st.word_last) state_next = S_FRESH;
      end
      S_FRESH: begin
        if (go || !st.fresh_emits) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.mode_val    = MODE_IDLE;
    cmd.sel         = SEL_TOKEN;
    fresh_need_next = fresh_need;
    case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (st.pend_any) begin
          cmd.pend_clear  = 1'b1;
          fresh_need_next = !st.eq;
        end else begin
          case (st.mode)
            MODE_NUMBER: begin
              if (st.digit) begin
                cmd.acc_step = 1'b1;
              end else begin
                cmd.mode_we     = 1'b1;
                fresh_need_next = 1'b1;
              end
            end
            MODE_IDENT: begin
              if (st.alnum) begin
                if (st.id_full) begin
                  cmd.mode_we     = 1'b1;
                  cmd.mode_val    = MODE_DISCARD;
                  fresh_need_next = 1'b0;
                end else begin
                  cmd.id_push = 1'b1;
                end
              end else begin
                cmd.mode_we     = 1'b1;
                cmd.word_clr    = 1'b1;
                fresh_need_next = 1'b1;
              end
            end
            MODE_DISCARD: begin
              cmd.mode_we = !st.alnum;
            end
            default: ;
          endcase
        end
      end
      S_TOKEN: begin
        cmd.emit = go && can_emit;
        cmd.sel  = SEL_TOKEN;
        cmd.last = !fresh_need || !st.fresh_emits;
      end
      S_IDHEAD: begin
        cmd.emit = go && can_emit;
        cmd.sel  = SEL_IDHEAD;
        cmd.last = 1'b0;
      end
      S_WORD: begin
        cmd.emit     = go && can_emit;
        cmd.sel      = SEL_WORD;
        cmd.last     = st.word_last && !st.fresh_emits;
        cmd.word_inc = go && !st.word_last;
      end
      S_FRESH: begin
        cmd.sel   = SEL_FRESH;
        cmd.last  = 1'b1;
        cmd.emit  = st.fresh_emits && go && can_emit;
        cmd.fresh = go || !st.fresh_emits;
      end
      default: ;
    endcase
    if (emit_cnt == 4'(OUT_LIMIT - 1)) cmd.last = 1'b1;
  end
endmodule

### rtl/core/csl_dp.sv
// Lexer datapath: lexer state, identifier word store and result register.
// Depends on csl_pkg and csl_ram; commanded by csl_ctrl.
module csl_dp #(
  parameter int MAX_ID = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [7:0]                    byte_req,
  input  logic                          end_of_input,
  input  csl_pkg::cmd_t                 cmd,
  output csl_pkg::status_t              st,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [4:0]                    kind,
  output logic [31:0]                   value,
  output logic [$clog2(MAX_ID+1)-1:0]   id_length,
  output logic [63:0]                   text,
  output logic [23:0]                   line,
  output logic                          last
);
  import csl_pkg::*;

  localparam int CW    = $clog2(MAX_ID + 1);
  localparam int WORDS = (MAX_ID + 7) / 8;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [7:0]     c;
  logic           eoi;
  logic [23:0]    line_cnt;
  mode_t          mode;
  op_t            pend;
  logic [31:0]    acc;
  logic [CW-1:0]  count;
  logic [63:0]    word;
  logic [4:0]     tok;
  logic [WAW-1:0] widx, widx_next;

  fclass_t        fc;
  logic           digit, letter, eq;
  logic [3:0]     dval;
  logic [4:0]     kw_kind, tok_next, fresh_kind;
  logic           push, push_start;
  logic [CW-1:0]  base;
  logic [2:0]     pos;
  logic [63:0]    word_new;
  logic [63:0]    ram_rd;
  logic [WAW-1:0] last_idx;

  assign fc     = classify(c);
  assign digit  = !eoi && fc == FC_DIGIT;
  assign letter = !eoi && fc == FC_LETTER;
  assign eq     = !eoi && c == 8'h3D;
  assign dval   = 4'(c - 8'h30);

  always_comb begin
    kw_kind = KIND_IDENT;
    if (count == CW'(3) && word[23:0] == KW_INT) kw_kind = KIND_INT;
    else if (count == CW'(4) && word[31:0] == KW_VOID) kw_kind = KIND_VOID;
    else if (count == CW'(6) && word[47:0] == KW_RETURN) kw_kind = KIND_RETURN;
    else if (count == CW'(5) && word[39:0] == KW_PRINT) kw_kind = KIND_PRINT;
  end

  always_comb begin
    if (pend != OP_NONE)         tok_next = op_kind(pend, eq);
    else if (mode == MODE_NUMBER) tok_next = KIND_NUMBER;
    else if (digit || letter)     tok_next = KIND_TOOLONG;
    else                          tok_next = kw_kind;
  end

  always_comb begin
    if (eoi)                  fresh_kind = KIND_END;
    else if (fc == FC_SINGLE) fresh_kind = single_kind(c);
    else                      fresh_kind = KIND_UNKNOWN;
  end

  // character push into the current word; a full word goes to the store
  assign push_start = cmd.fresh && letter;
  assign push       = cmd.id_push || push_start;
  assign base       = push_start ? '0 : count;
  assign pos        = base[2:0];
  assign word_new   = (pos == 3'd0 ? 64'd0 : word) | ({56'd0, c} << {pos, 3'b000});

  assign last_idx  = WAW'((count - CW'(1)) >> 3);
  assign widx_next = cmd.word_clr ? '0 : (cmd.word_inc ? widx + WAW'(1) : widx);

  csl_ram #(.WIDTH(64), .DEPTH(WORDS)) u_words (
    .clk   (clk),
    .we    (push && pos == 3'd7),
    .waddr (WAW'(base >> 3)),
    .wdata (word_new),
    .raddr (widx_next),
    .rdata (ram_rd)
  );

  always_comb begin
    st.pend_any    = pend != OP_NONE;
    st.eq          = eq;
    st.mode        = mode;
    st.digit       = digit;
    st.alnum       = digit || letter;
    st.id_full     = count == CW'(MAX_ID);
    st.is_kw       = kw_kind != KIND_IDENT;
    st.fresh_emits = eoi || fc == FC_SINGLE || fc == FC_UNKNOWN;
    st.word_last   = widx == last_idx;
    st.slot_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_cnt  <= 24'd1;
      mode      <= MODE_IDLE;
      pend      <= OP_NONE;
      acc       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture && !end_of_input && byte_req == 8'h0A && line_cnt != LINE_MAX) begin
        line_cnt <= line_cnt + 24'd1;
      end
      if (cmd.pend_clear) pend <= OP_NONE;
      if (cmd.mode_we)    mode <= cmd.mode_val;
      if (cmd.acc_step)   acc <= (acc << 3) + (acc << 1) + {28'd0, dval};
      if (push)           count <= base + CW'(1);
      if (cmd.fresh && !eoi) begin
        case (fc)
          FC_PEND:   pend <= pend_op(c);
          FC_DIGIT: begin
            acc  <= {28'd0, dval};
            mode <= MODE_NUMBER;
          end
          FC_LETTER: mode <= MODE_IDENT;
          default: ;
        endcase
      end
      if (cmd.emit)           out_valid <= 1'b1;
      else if (!out_stall)    out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c   <= byte_req;
      eoi <= end_of_input;
    end
    if (cmd.eval) tok <= tok_next;
    if (push)     word <= word_new;
    widx <= widx_next;
    if (cmd.emit) begin
      line <= line_cnt;
      last <= cmd.last;
      case (cmd.sel)
        SEL_TOKEN: begin
          kind      <= tok;
          value     <= (tok == KIND_NUMBER) ? acc : '0;
          id_length <= '0;
          text      <= '0;
        end
        SEL_IDHEAD: begin
          kind      <= KIND_IDENT;
          value     <= '0;
          id_length <= count;
          text      <= '0;
        end
        SEL_WORD: begin
          kind      <= KIND_TEXT;
          value     <= '0;
          id_length <= '0;
          text      <= (count[2:0] != 3'd0 && widx == last_idx) ? word : ram_rd;
        end
        default: begin
          kind      <= fresh_kind;
          value     <= '0;
          id_length <= '0;
          text      <= '0;
        end
      endcase
    end
  end
endmodule
